[rtl/wsrm_pkg.sv]
// ----------------------------------------------------------------------------
// wsrm_pkg: shared types and constants of the wildcard star matcher
// Request codes, special pattern bytes and the link between matcher cells.
// ----------------------------------------------------------------------------
package wsrm_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_TEXT   = 2'd2;
  localparam logic [1:0] CMD_END    = 2'd3;

  localparam logic [7:0] CHR_ANY  = 8'h2E;
  localparam logic [7:0] CHR_STAR = 8'h2A;

  // What a cell shows its right-hand neighbor.
  typedef struct packed {
    logic       go;    // update wave reaches the next cell
    logic       flag;  // new prefix-match flag of this cell
    logic       old;   // flag of this cell before the update
    logic       lnew;  // new flag of the cell to the left
    logic       elem;  // this position holds a real pattern element
    logic [7:0] pat;   // pattern byte held here
  } link_t;

  function automatic logic byte_fits(input logic [7:0] text, input logic [7:0] pat);
    return (pat == CHR_ANY) || (text == pat);
  endfunction

endpackage

[rtl/wsrm_cell.sv]
// ----------------------------------------------------------------------------
// wsrm_cell: one pattern position of the matcher chain
// Holds a pattern byte and its prefix-match flag, updates the flag when the
// wave arrives from the left and hands the wave on to the right.
// ----------------------------------------------------------------------------
module wsrm_cell
  import wsrm_pkg::*;
#(
  parameter int IDX = 1,
  parameter int LW  = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [LW-1:0] len,
  input  logic          wr_en,
  input  logic [7:0]    wr_byte,
  input  logic          first_row,
  input  logic [7:0]    text_byte,
  input  link_t         left,
  output link_t         right
);

  logic [7:0] pat_r;
  logic       flag_r;
  logic       flag_nxt;
  logic       old_r;
  logic       lnew_r;
  logic       go_r;
  logic       is_star;

  assign is_star = (pat_r == CHR_STAR);

  always_comb begin
    if (is_star) begin
      // zero copies, or one more copy of the element to the left
      flag_nxt = left.elem &&
                 (left.lnew || (!first_row && flag_r && byte_fits(text_byte, left.pat)));
    end else begin
      flag_nxt = !first_row && left.old && byte_fits(text_byte, pat_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r   <= 1'b0;
      flag_r <= 1'b0;
    end else begin
      go_r <= left.go;
      if (left.go) begin
        flag_r <= flag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (left.go) begin
      old_r  <= flag_r;
      lnew_r <= left.flag;
    end
    if (wr_en && (len == LW'(IDX - 1))) begin
      pat_r <= wr_byte;
    end
  end

  assign right = '{go: go_r, flag: flag_r, old: old_r, lnew: lnew_r,
                   elem: 1'b1, pat: pat_r};

endmodule

[rtl/wildcard_star_regex_matcher.sv]
// ----------------------------------------------------------------------------
// wildcard_star_regex_matcher: whole-text matcher for patterns with '.' and '*'
// A chain of cells, one per pattern position, keeps a column of prefix flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: in_cmd selects
//   clear pattern, append pattern byte (in_data_byte), text byte
//   (in_data_byte) or end of text. Only end of text yields a result on the
//   output channel (out_valid/out_ready): out_matched and out_overflow.
//   Every request starts an update wave that walks the cell chain one cell
//   per cycle, and the block takes no new request until the wave is done;
//   the chain length sets how long that takes. An end-of-text result is registered
//   at the accepting edge and shows on out_valid in the next cycle.
//   A pending result does not block the next request, but a second
//   end-of-text waits until the first result is taken.
//   Appends past MAX_PATTERN bytes are dropped and set a sticky overflow
//   flag, cleared by the next clear request; while it is set, matched is 0.
//   Reset (rst_n low, synchronous) empties the pattern, clears overflow and
//   arms the block for a new text; no clearing pass is needed.
// ----------------------------------------------------------------------------
module wildcard_star_regex_matcher
  import wsrm_pkg::*;
#(
  parameter int MAX_PATTERN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_matched,
  output logic       out_overflow
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int IW = $clog2(MAX_PATTERN);

  logic [LW-1:0] len_r;
  logic [LW-1:0] cnt_r;
  logic          ovf_r;
  logic          z_r;
  logic          zold_r;
  logic          first_r;
  logic [7:0]    byte_r;
  logic          start_r;
  logic          out_valid_r;
  logic          out_matched_r;
  logic          out_overflow_r;

  logic                   in_acc;
  logic                   full;
  logic                   wr_en;
  logic                   rd_flag;
  logic [IW-1:0]          rd_idx;
  logic [MAX_PATTERN-1:0] col;
  link_t                  links [0:MAX_PATTERN];

  assign full     = (len_r == LW'(MAX_PATTERN));
  // only an end-of-text request needs the result register free
  assign in_ready = (cnt_r == '0) &&
                    (!out_valid_r || out_ready || (in_cmd != CMD_END));
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = in_acc && (in_cmd == CMD_APPEND) && !full;

  // position zero: the empty pattern prefix
  assign links[0] = '{go: start_r, flag: first_r, old: zold_r, lnew: 1'b0,
                      elem: 1'b0, pat: 8'h00};

  for (genvar k = 1; k <= MAX_PATTERN; k++) begin : g_cell
    wsrm_cell #(.IDX(k), .LW(LW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .len       (len_r),
      .wr_en     (wr_en),
      .wr_byte   (in_data_byte),
      .first_row (first_r),
      .text_byte (byte_r),
      .left      (links[k-1]),
      .right     (links[k])
    );
    assign col[k-1] = links[k].flag;
  end

  assign rd_idx  = IW'(len_r - LW'(1));
  assign rd_flag = (len_r == '0) ? z_r : col[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r          <= '0;
      cnt_r          <= '0;
      ovf_r          <= 1'b0;
      z_r            <= 1'b1;
      zold_r         <= 1'b1;
      first_r        <= 1'b1;
      start_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      start_r <= in_acc;
      if (in_acc) begin
        cnt_r <= LW'(MAX_PATTERN);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - LW'(1);
      end

      if (in_acc && (in_cmd == CMD_END)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_acc) begin
        case (in_cmd)
          CMD_CLEAR: begin
            len_r   <= '0;
            ovf_r   <= 1'b0;
            z_r     <= 1'b1;
            first_r <= 1'b1;
          end
          CMD_APPEND: begin
            if (full) begin
              ovf_r <= 1'b1;
            end else begin
              len_r <= len_r + LW'(1);
            end
            z_r     <= 1'b1;
            first_r <= 1'b1;
          end
          CMD_TEXT: begin
            zold_r  <= z_r;
            z_r     <= 1'b0;
            first_r <= 1'b0;
          end
          default: begin
            z_r         <= 1'b1;
            first_r     <= 1'b1;
          end
        endcase
      end
    end
  end

  // result and text byte registers
  always_ff @(posedge clk) begin
    if (in_acc && (in_cmd == CMD_END)) begin
      out_matched_r  <= rd_flag && !ovf_r;
      out_overflow_r <= ovf_r;
    end
    if (in_acc && (in_cmd == CMD_TEXT)) begin
      byte_r <= in_data_byte;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_matched  = out_matched_r;
  assign out_overflow = out_overflow_r;

  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && (in_cmd == CMD_END)))
    else $error("result appeared without an end-of-text request");

  a_no_match_on_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_matched_r && out_overflow_r))
    else $error("match reported with overflow set");

  a_wave_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (!in_ready && start_r))
    else $error("request accepted while update wave pending");

  a_overflow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> full)
    else $error("overflow set with room in the pattern store");

endmodule
